// ----- rtl/cse_pkg.sv -----
// shared types and constants of the chebyshev series evaluator
// no dependencies; used by the top rtl file of the block
`timescale 1ns / 1ps

package cse_pkg;

    // default sizing of the evaluator
    localparam int DEF_MAX_EXTENT  = 16;
    localparam int DEF_MAX_DIMS    = 3;
    localparam int DEF_STORE_DEPTH = 4096;

    // field widths
    localparam int COEF_W  = 32;
    localparam int COORD_W = 32;
    localparam int WORD_W  = 40;
    localparam int CNT_W   = 13;
    localparam int DIMS_W  = 2;
    localparam int EXT_W   = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_0 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_1 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_2 = 2'd3;

    // load counter saturates here
    localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

    // 40-bit word limits
    localparam logic signed [WORD_W-1:0] W40_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [WORD_W-1:0] W40_MIN = 40'sh80_0000_0000;

    // input word: one coefficient plus the evaluation point
    typedef struct packed {
        logic signed [COEF_W-1:0]  coefficient;
        logic                      last_coefficient;
        logic signed [COORD_W-1:0] coord_first;
        logic signed [COORD_W-1:0] coord_second;
        logic signed [COORD_W-1:0] coord_third;
    } t_in;

    // output word: evaluated series and status
    typedef struct packed {
        logic signed [COEF_W-1:0] series_value;
        logic                     size_mismatch;
        logic                     saturated;
    } t_out;

endpackage

// ----- rtl/cse_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module cse_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/chebyshev_series_evaluator_top.sv -----
// Load: one coefficient word per cycle while ready. A final word with a size
// mismatch goes straight to the done step, which raises its result word.
// Otherwise a pass step per pass in use, and per recurrence step mag, mulh,
// mull, round, sign, acc on one shared 20x32 multiplier; not ready meanwhile,
// nor while a finished result word still waits. Reset clears control, counter
// and configuration; the coefficient store is not cleared and needs no pass.
`timescale 1ns / 1ps

module chebyshev_series_evaluator_top #(
    parameter int MAX_EXTENT  = cse_pkg::DEF_MAX_EXTENT,
    parameter int MAX_DIMS    = cse_pkg::DEF_MAX_DIMS,
    parameter int STORE_DEPTH = cse_pkg::DEF_STORE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  cse_pkg::t_in                   i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output cse_pkg::t_out                  o_out
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int KW = $clog2(MAX_EXTENT + 1);
    localparam int PW = 3 * KW;
    localparam int WW = cse_pkg::WORD_W;

    // sequencer codes
    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_PASS  = 4'd1;
    localparam logic [3:0] S_MAG   = 4'd2;
    localparam logic [3:0] S_MULH  = 4'd3;
    localparam logic [3:0] S_MULL  = 4'd4;
    localparam logic [3:0] S_ROUND = 4'd5;
    localparam logic [3:0] S_SIGN  = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;

    // configuration registers
    logic [cse_pkg::DIMS_W-1:0] r_cfg_dims;
    logic [cse_pkg::EXT_W-1:0]  r_cfg_ext [0:2];

    // load side
    logic [cse_pkg::CNT_W-1:0] r_count;
    logic [cse_pkg::CNT_W-1:0] n_count;

    // evaluation control
    logic [cse_pkg::DIMS_W-1:0]        r_dims;
    logic [1:0]                        r_pass;
    logic [KW-1:0]                     r_ext [0:2];
    logic [PW-1:0]                     r_slc [0:2];
    logic signed [cse_pkg::COORD_W-1:0] r_coord [0:2];
    logic [KW-1:0]                     r_ecur;
    logic [PW-1:0]                     r_scur;
    logic [PW-1:0]                     r_slice;
    logic [AW-1:0]                     r_base;
    logic [KW-1:0]                     r_k;
    logic                              r_mis;
    logic                              r_clip;

    // datapath registers
    logic signed [WW-1:0]              r_lower;
    logic signed [WW-1:0]              r_upper;
    logic [WW-1:0]                     r_mag;
    logic                              r_neg;
    logic [cse_pkg::COORD_W-1:0]       r_xmag;
    logic                              r_xneg;
    logic [51:0]                       r_ph;
    logic [51:0]                       r_pl;
    logic [42:0]                       r_q;
    logic signed [WW-1:0]              r_prod;
    logic signed [WW-1:0]              r_result;

    // output register
    logic          r_out_valid;
    cse_pkg::t_out r_out;

    // effective dimension count and extents
    logic [cse_pkg::DIMS_W-1:0] w_dims;
    logic [KW-1:0]              w_ext [0:2];
    logic [2*KW-1:0]            w_p12;
    logic [PW-1:0]              w_product;
    logic                       w_mismatch;

    always_comb begin
        if (r_cfg_dims == '0) begin
            w_dims = cse_pkg::DIMS_W'(1);
        end else if (32'(r_cfg_dims) > 32'(MAX_DIMS)) begin
            w_dims = cse_pkg::DIMS_W'(MAX_DIMS);
        end else begin
            w_dims = r_cfg_dims;
        end
    end

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            if (32'(d) >= 32'(w_dims) || r_cfg_ext[d] == '0) begin
                w_ext[d] = KW'(1);
            end else if (32'(r_cfg_ext[d]) > 32'(MAX_EXTENT)) begin
                w_ext[d] = KW'(MAX_EXTENT);
            end else begin
                w_ext[d] = KW'(r_cfg_ext[d]);
            end
        end
    end

    assign w_p12     = w_ext[1] * w_ext[2];
    assign w_product = w_ext[0] * w_p12;

    // saturating load count including the word being accepted
    assign n_count = (r_count == cse_pkg::CNT_MAX) ? r_count : r_count + 1'b1;

    assign w_mismatch = (32'(n_count) != 32'(w_product)) ||
                        (32'(w_product) > 32'(STORE_DEPTH));

    logic w_accept;
    assign o_in_ready = (r_state == S_LOAD);
    assign w_accept   = i_in_valid && o_in_ready;

    // shared multiplier: upper half of the magnitude first, then the lower half
    logic [19:0] w_mul_a;
    logic [51:0] w_mul;
    assign w_mul_a = (r_state == S_MULH) ? r_mag[39:20] : r_mag[19:0];
    assign w_mul   = w_mul_a * r_xmag;

    // round to nearest of the split product, shift 30 on the closing step
    logic [71:0] w_half;
    logic [71:0] w_rsum;
    logic [42:0] w_qnext;
    assign w_half  = (r_k == KW'(1)) ? (72'(1) << 29) : (72'(1) << 28);
    assign w_rsum  = {r_ph, 20'd0} + 72'(r_pl) + w_half;
    assign w_qnext = (r_k == KW'(1)) ? 43'(w_rsum[71:30]) : w_rsum[71:29];

    // clamp and sign of the coordinate product
    logic [42:0]          w_qlim;
    logic signed [WW-1:0] w_prod;
    logic                 w_prod_clip;
    assign w_qlim = 43'(1) << 39;
    always_comb begin
        w_prod_clip = 1'b0;
        if (r_neg) begin
            w_prod = (r_q >= w_qlim) ? cse_pkg::W40_MIN : WW'(40'd0 - 40'(r_q));
        end else if (r_q >= w_qlim) begin
            w_prod      = cse_pkg::W40_MAX;
            w_prod_clip = 1'b1;
        end else begin
            w_prod = WW'(r_q);
        end
    end

    // recurrence sum c + product - upper, saturated once
    logic [WW-1:0]        w_rdata;
    logic signed [41:0]   w_acc;
    logic signed [WW-1:0] w_sat;
    logic                 w_acc_clip;
    assign w_acc = 42'($signed(w_rdata)) + 42'(r_prod) - 42'(r_upper);
    always_comb begin
        w_acc_clip = 1'b1;
        if (w_acc > 42'(cse_pkg::W40_MAX)) begin
            w_sat = cse_pkg::W40_MAX;
        end else if (w_acc < 42'(cse_pkg::W40_MIN)) begin
            w_sat = cse_pkg::W40_MIN;
        end else begin
            w_sat      = WW'(w_acc);
            w_acc_clip = 1'b0;
        end
    end

    // store port control
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [WW-1:0] w_ram_wdata;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    logic          w_fold_end;

    assign w_fold_end  = (r_state == S_ACC) && (r_k == KW'(1));
    assign w_ram_re    = (r_state == S_MAG);
    assign w_ram_raddr = AW'(r_base + AW'(r_k) - AW'(1));

    always_comb begin
        if (r_state == S_LOAD) begin
            w_ram_we    = w_accept && (32'(r_count) < 32'(STORE_DEPTH));
            w_ram_waddr = AW'(r_count);
            w_ram_wdata = WW'(i_in.coefficient);
        end else begin
            w_ram_we    = w_fold_end;
            w_ram_waddr = AW'(r_slice);
            w_ram_wdata = w_sat;
        end
    end

    cse_ram #(
        .WIDTH (WW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rdata)
    );

    // final 32-bit saturation of the folded value
    logic signed [cse_pkg::COEF_W-1:0] w_final;
    logic                              w_final_clip;
    always_comb begin
        w_final_clip = 1'b1;
        if (r_result > 40'sh00_7FFF_FFFF) begin
            w_final = 32'sh7FFF_FFFF;
        end else if (r_result < -40'sh00_8000_0000) begin
            w_final = 32'sh8000_0000;
        end else begin
            w_final      = cse_pkg::COEF_W'(r_result);
            w_final_clip = 1'b0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dims   <= cse_pkg::DIMS_W'(1);
            r_cfg_ext[0] <= cse_pkg::EXT_W'(1);
            r_cfg_ext[1] <= cse_pkg::EXT_W'(1);
            r_cfg_ext[2] <= cse_pkg::EXT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cse_pkg::CFG_DIMS:  r_cfg_dims   <= i_cfg_data[cse_pkg::DIMS_W-1:0];
                cse_pkg::CFG_EXT_0: r_cfg_ext[0] <= i_cfg_data;
                cse_pkg::CFG_EXT_1: r_cfg_ext[1] <= i_cfg_data;
                cse_pkg::CFG_EXT_2: r_cfg_ext[2] <= i_cfg_data;
                default:            r_cfg_dims   <= r_cfg_dims;
            endcase
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_mis       <= 1'b0;
            r_clip      <= 1'b0;
            r_pass      <= '0;
            r_k         <= '0;
            r_slice     <= '0;
            r_base      <= '0;
        end else begin
            // result word valid: a new word from done wins over the handoff
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        r_count <= i_in.last_coefficient ? '0 : n_count;
                        if (i_in.last_coefficient) begin
                            r_mis   <= w_mismatch;
                            r_clip  <= 1'b0;
                            r_pass  <= '0;
                            r_state <= w_mismatch ? S_DONE : S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    r_slice <= '0;
                    r_base  <= '0;
                    r_k     <= r_ext[r_pass];
                    r_state <= S_MAG;
                end
                S_MAG:   r_state <= S_MULH;
                S_MULH:  r_state <= S_MULL;
                S_MULL:  r_state <= S_ROUND;
                S_ROUND: r_state <= S_SIGN;
                S_SIGN: begin
                    r_clip  <= r_clip | w_prod_clip;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_clip <= r_clip | w_acc_clip;
                    if (r_k != KW'(1)) begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_MAG;
                    end else if (r_slice != r_scur - 1'b1) begin
                        r_slice <= r_slice + 1'b1;
                        r_base  <= r_base + AW'(r_ecur);
                        r_k     <= r_ecur;
                        r_state <= S_MAG;
                    end else if (2'(r_pass + 1'b1) == r_dims) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pass  <= r_pass + 1'b1;
                        r_state <= S_PASS;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                if (w_accept && i_in.last_coefficient) begin
                    r_dims     <= w_dims;
                    r_ext[0]   <= w_ext[0];
                    r_ext[1]   <= w_ext[1];
                    r_ext[2]   <= w_ext[2];
                    r_slc[0]   <= PW'(w_p12);
                    r_slc[1]   <= PW'(w_ext[2]);
                    r_slc[2]   <= PW'(1);
                    r_coord[0] <= i_in.coord_first;
                    r_coord[1] <= i_in.coord_second;
                    r_coord[2] <= i_in.coord_third;
                end
            end
            S_PASS: begin
                r_ecur  <= r_ext[r_pass];
                r_scur  <= r_slc[r_pass];
                r_xneg  <= r_coord[r_pass][cse_pkg::COORD_W-1];
                r_xmag  <= r_coord[r_pass][cse_pkg::COORD_W-1] ?
                           cse_pkg::COORD_W'(32'd0 - r_coord[r_pass]) :
                           cse_pkg::COORD_W'(r_coord[r_pass]);
                r_lower <= '0;
                r_upper <= '0;
            end
            S_MAG: begin
                r_mag <= r_lower[WW-1] ? WW'(40'd0 - r_lower) : WW'(r_lower);
                r_neg <= r_lower[WW-1] ^ r_xneg;
            end
            S_MULH:  r_ph <= w_mul;
            S_MULL:  r_pl <= w_mul;
            S_ROUND: r_q <= w_qnext;
            S_SIGN:  r_prod <= w_prod;
            S_ACC: begin
                if (r_k != KW'(1)) begin
                    r_upper <= r_lower;
                    r_lower <= w_sat;
                end else begin
                    r_upper  <= '0;
                    r_lower  <= '0;
                    r_result <= w_sat;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_mis) begin
                        r_out.series_value  <= '0;
                        r_out.size_mismatch <= 1'b1;
                        r_out.saturated     <= 1'b0;
                    end else begin
                        r_out.series_value  <= w_final;
                        r_out.size_mismatch <= 1'b0;
                        r_out.saturated     <= r_clip | w_final_clip;
                    end
                end
            end
            default: r_q <= r_q;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    // a result word appears only from the done step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside done step");

    // mismatch words carry zero value and no clip
    a_mis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.size_mismatch) |->
            (o_out.series_value == '0 && !o_out.saturated))
        else $error("mismatch word has nonzero payload");

    // folded word lands inside the slice range of the pass
    a_fold_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fold_end |-> (r_slice < r_scur && r_k <= r_ecur))
        else $error("fold write outside slice range");

    // a final word with a size mismatch skips every fold pass
    a_mis_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.last_coefficient && w_mismatch) |=> (r_state == S_DONE))
        else $error("mismatch did not go straight to done");
`endif

endmodule
